// ===== rtl/wvc_pkg.sv =====
// Shared types, widths and constants of the weighted vote combiner.
package wvc_pkg;

    localparam int LABEL_W    = 10;
    localparam int CONF_W     = 16;
    localparam int WEIGHT_W   = 16;
    localparam int NSYS_W     = 5;
    localparam int VOTES_W    = 5;
    localparam int SUM_W      = 20;
    localparam int SCORE_W    = 24;
    localparam int DIV_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LFSR_W     = 16;
    localparam int FRAC_SHIFT = 12;

    localparam int DEF_MAX_SYSTEMS     = 16;
    localparam int DEF_VOCABULARY_SIZE = 1024;

    localparam logic [VOTES_W-1:0] VOTES_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [LFSR_W-1:0]  LFSR_SEED = 16'hACE1;

    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_FREQUENCY = 16'd4096;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_OTHER     = 16'd0;
    localparam logic [NSYS_W-1:0]   RST_NUMBER_OF_SYSTEMS = 5'd2;
    localparam logic [LABEL_W-1:0]  RST_NULL_LABEL       = 10'd1023;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_FREQUENCY          = 3'd0,
        CFG_WEIGHT_CONFIDENCE_SUM     = 3'd1,
        CFG_WEIGHT_AVERAGE_CONFIDENCE = 3'd2,
        CFG_WEIGHT_MAXIMUM_CONFIDENCE = 3'd3,
        CFG_NUMBER_OF_SYSTEMS         = 3'd4,
        CFG_RANDOM_TIE_BREAK          = 3'd5,
        CFG_NULL_LABEL                = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [VOTES_W-1:0] votes;
        logic [SUM_W-1:0]   sum;
        logic [CONF_W-1:0]  max;
        logic [SCORE_W-1:0] score;
    } entry_t;

    typedef struct packed {
        logic load_new;
        logic merge;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== rtl/weighted_vote_combiner_unit.sv =====
// Top level of the weighted vote combiner: candidate ring, scoring sequencer, ports.
//
// Channel   Direction  Handshake                 Payload
// input     in         start & !busy             label_id, confidence, last
// result    out        result_valid (one cycle)  winner_label, winner_score
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// An item that is not marked last leaves the unit idle: its label is matched against
// every cell at once and merged or added. On a last item the ring rotates so that
// each candidate in turn reaches the head cell, where one shared multiplier and a
// bit-serial divider work out its four terms; an empty cell is passed over. With
// random tie breaking on, one pass of the ring counts the ties and a draw state
// follows; a second pass finds the drawn candidate only when two or more tie. An
// output state ends the slot. Reset is asynchronous and active low; the table
// comes up empty.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
module weighted_vote_combiner_unit #(
    parameter int MAX_SYSTEMS     = wvc_pkg::DEF_MAX_SYSTEMS,
    parameter int VOCABULARY_SIZE = wvc_pkg::DEF_VOCABULARY_SIZE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [wvc_pkg::LABEL_W-1:0]    label_id,
    input  logic [wvc_pkg::CONF_W-1:0]     confidence,
    input  logic                           last,
    output logic                           result_valid,
    output logic [wvc_pkg::LABEL_W-1:0]    winner_label,
    output logic [wvc_pkg::SCORE_W-1:0]    winner_score,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wvc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wvc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IW = (MAX_SYSTEMS > 1) ? $clog2(MAX_SYSTEMS) : 1;
    localparam int CW = $clog2(MAX_SYSTEMS + 1);
    localparam int MUL_W = wvc_pkg::SUM_W + wvc_pkg::WEIGHT_W;
    localparam int TOT_W = wvc_pkg::DIV_W + 2;

    // The sequencer walks through these one-hot states.
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MUL  = 10'b0000000010,
        S_DIV1 = 10'b0000000100,
        S_DIV2 = 10'b0000001000,
        S_DIV3 = 10'b0000010000,
        S_SUM  = 10'b0000100000,
        S_TIES = 10'b0001000000,
        S_DRAW = 10'b0010000000,
        S_PICK = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    // Configuration registers.
    logic [wvc_pkg::WEIGHT_W-1:0] wf_reg, ws_reg, wa_reg, wm_reg;
    logic [wvc_pkg::NSYS_W-1:0]   nsys_reg;
    logic                         rand_reg;
    logic [wvc_pkg::LABEL_W-1:0]  null_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wf_reg   <= wvc_pkg::RST_WEIGHT_FREQUENCY;
            ws_reg   <= wvc_pkg::RST_WEIGHT_OTHER;
            wa_reg   <= wvc_pkg::RST_WEIGHT_OTHER;
            wm_reg   <= wvc_pkg::RST_WEIGHT_OTHER;
            nsys_reg <= wvc_pkg::RST_NUMBER_OF_SYSTEMS;
            rand_reg <= 1'b0;
            null_reg <= wvc_pkg::RST_NULL_LABEL;
        end
        else if (cfg_valid)
        begin
            case (wvc_pkg::cfg_index_t'(cfg_index))
                wvc_pkg::CFG_WEIGHT_FREQUENCY:          wf_reg   <= cfg_data;
                wvc_pkg::CFG_WEIGHT_CONFIDENCE_SUM:     ws_reg   <= cfg_data;
                wvc_pkg::CFG_WEIGHT_AVERAGE_CONFIDENCE: wa_reg   <= cfg_data;
                wvc_pkg::CFG_WEIGHT_MAXIMUM_CONFIDENCE: wm_reg   <= cfg_data;
                wvc_pkg::CFG_NUMBER_OF_SYSTEMS:
                    nsys_reg <= cfg_data[wvc_pkg::NSYS_W-1:0];
                wvc_pkg::CFG_RANDOM_TIE_BREAK:          rand_reg <= cfg_data[0];
                wvc_pkg::CFG_NULL_LABEL:
                    null_reg <= cfg_data[wvc_pkg::LABEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state.
    state_t                      state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [IW-1:0]               k_reg, k_next;
    logic [CW-1:0]               ties_reg, ties_next;
    logic [CW-1:0]               pick_reg, pick_next;
    logic                        picked_reg, picked_next;
    logic [wvc_pkg::LFSR_W-1:0]  lfsr_reg, lfsr_next;
    logic                        rv_reg, rv_next;

    // Datapath registers, no reset needed.
    logic [wvc_pkg::SCORE_W-1:0] p2_reg, p3_reg;
    logic [wvc_pkg::SUM_W-1:0]   p4_reg;
    logic [wvc_pkg::DIV_W-1:0]   q1_reg, q2_reg;
    logic [wvc_pkg::SCORE_W-1:0] best_reg, best_next;
    logic [wvc_pkg::LABEL_W-1:0] best_label_reg, best_label_next;
    logic [wvc_pkg::LABEL_W-1:0] wl_reg;
    logic [wvc_pkg::SCORE_W-1:0] ws_out_reg;

    // Candidate ring.
    wvc_pkg::entry_t    cell_q [MAX_SYSTEMS];
    wvc_pkg::entry_t    shift_in [MAX_SYSTEMS];
    wvc_pkg::cell_ctl_t ctl [MAX_SYSTEMS];
    wvc_pkg::entry_t    head, ring_back;

    logic                        accept;
    logic                        rotate;
    logic                        head_use;
    logic                        head_tied;
    logic                        pass_end;
    logic [wvc_pkg::LABEL_W-1:0] eff_label;
    logic [MAX_SYSTEMS-1:0]      hit;
    logic                        found_any;
    logic [IW-1:0]               found_idx;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && (state_reg == S_IDLE);
    assign head     = cell_q[0];
    assign head_use = CW'(k_reg) < count_reg;
    assign head_tied = head_use && (head.score == best_reg);
    assign pass_end = (k_reg == IW'(MAX_SYSTEMS - 1));

    // Labels outside the vocabulary count as the null label.
    assign eff_label = (32'(label_id) >= 32'(VOCABULARY_SIZE)) ? null_reg : label_id;

    always_comb
    begin
        found_any = 1'b0;
        found_idx = '0;
        for (int i = MAX_SYSTEMS - 1; i >= 0; i--)
        begin
            hit[i] = (cell_q[i].label == eff_label) && (CW'(i) < count_reg);
            if (hit[i])
            begin
                found_any = 1'b1;
                found_idx = IW'(i);
            end
        end
    end

    assign rotate = ((state_reg == S_MUL) && !head_use) || (state_reg == S_SUM)
                    || (state_reg == S_TIES) || (state_reg == S_PICK);

    // Scoring pipeline: one shared multiplier and the divider.
    logic [wvc_pkg::SUM_W-1:0]                   mul_a;
    logic [wvc_pkg::WEIGHT_W-1:0]                mul_b;
    logic [MUL_W-1:0]                            mul_p;
    logic [wvc_pkg::VOTES_W+wvc_pkg::WEIGHT_W-1:0] freq_prod;
    logic                                        div_start;
    logic [wvc_pkg::DIV_W-1:0]                   div_dividend;
    logic [wvc_pkg::NSYS_W-1:0]                  div_divisor;
    logic [wvc_pkg::DIV_W-1:0]                   div_quotient;
    logic                                        div_done;
    logic [wvc_pkg::NSYS_W-1:0]                  n_div;
    logic [wvc_pkg::NSYS_W-1:0]                  v_div;
    logic [wvc_pkg::DIV_W-1:0]                   q3_eff;
    logic [TOT_W-1:0]                            total;
    logic [wvc_pkg::SCORE_W-1:0]                 score_sat;
    logic [wvc_pkg::LFSR_W-1:0]                  lfsr_step;
    logic [wvc_pkg::LFSR_W+CW-1:0]               draw_prod;

    always_comb
    begin
        case (state_reg)
            S_MUL:
            begin
                mul_a = head.sum;
                mul_b = ws_reg;
            end
            S_DIV1:
            begin
                mul_a = head.sum;
                mul_b = wa_reg;
            end
            default:
            begin
                mul_a = wvc_pkg::SUM_W'(head.max);
                mul_b = wm_reg;
            end
        endcase
    end

    assign mul_p     = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign freq_prod = (wvc_pkg::VOTES_W + wvc_pkg::WEIGHT_W)'(head.votes) *
                       (wvc_pkg::VOTES_W + wvc_pkg::WEIGHT_W)'(wf_reg);

    // A system count of zero divides as one; so would zero votes.
    assign n_div = (nsys_reg == '0) ? wvc_pkg::NSYS_W'(1) : nsys_reg;
    assign v_div = (head.votes == '0) ? wvc_pkg::NSYS_W'(1) : head.votes;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {freq_prod, 4'b0000};
        div_divisor  = n_div;
        case (state_reg)
            S_MUL:  div_start = head_use;
            S_DIV1:
            begin
                div_start    = div_done;
                div_dividend = wvc_pkg::DIV_W'(p2_reg);
            end
            S_DIV2:
            begin
                div_start    = div_done;
                div_dividend = wvc_pkg::DIV_W'(p3_reg);
                div_divisor  = v_div;
            end
            default: ;
        endcase
    end

    wvc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign q3_eff = (head.votes == '0) ? '0 : div_quotient;
    assign total  = TOT_W'(q1_reg) + TOT_W'(q2_reg) + TOT_W'(q3_eff) + TOT_W'(p4_reg);
    assign score_sat = (total > TOT_W'(wvc_pkg::SCORE_MAX))
                       ? wvc_pkg::SCORE_MAX : total[wvc_pkg::SCORE_W-1:0];

    // The head cell's entry goes round to the tail, carrying its fresh score from the sum state.
    always_comb
    begin
        ring_back = cell_q[0];
        if (state_reg == S_SUM)
        begin
            ring_back.score = score_sat;
        end
    end

    for (genvar g = 0; g < MAX_SYSTEMS; g++)
    begin : g_cell
        if (g < MAX_SYSTEMS - 1)
        begin : g_mid
            assign shift_in[g] = cell_q[g+1];
        end
        else
        begin : g_tail
            assign shift_in[g] = ring_back;
        end

        assign ctl[g].shift    = rotate;
        assign ctl[g].merge    = accept && found_any && (found_idx == IW'(g));
        assign ctl[g].load_new = accept && !found_any && (count_reg == CW'(g));

        wvc_cell u_cell (
            .clk      (clk),
            .ctl      (ctl[g]),
            .label    (eff_label),
            .conf     (confidence),
            .shift_in (shift_in[g]),
            .entry    (cell_q[g])
        );
    end

    // Taps x^16 + x^14 + x^13 + x^11 + 1, shifting right.
    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                        lfsr_reg[wvc_pkg::LFSR_W-1:1]};
    assign draw_prod = (wvc_pkg::LFSR_W + CW)'(lfsr_step) * (wvc_pkg::LFSR_W + CW)'(ties_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        ties_next       = ties_reg;
        pick_next       = pick_reg;
        picked_next     = picked_reg;
        lfsr_next       = lfsr_reg;
        rv_next         = 1'b0;
        best_next       = best_reg;
        best_label_next = best_label_reg;
        if (rotate)
        begin
            k_next = pass_end ? '0 : k_reg + IW'(1);
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // A new label is dropped once the table is full.
                    if (!found_any && (count_reg < CW'(MAX_SYSTEMS)))
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (last)
                    begin
                        state_next = S_MUL;
                        k_next     = '0;
                    end
                end
            end
            S_MUL:
            begin
                if (head_use)
                begin
                    state_next = S_DIV1;
                end
                else if (pass_end)
                begin
                    state_next = rand_reg ? S_TIES : S_OUT;
                    ties_next  = '0;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    state_next = S_DIV3;
                end
            end
            S_DIV3:
            begin
                if (div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                // First highest score wins unless a draw follows.
                if ((k_reg == '0) || (score_sat > best_reg))
                begin
                    best_next       = score_sat;
                    best_label_next = head.label;
                end
                if (pass_end)
                begin
                    state_next = rand_reg ? S_TIES : S_OUT;
                    ties_next  = '0;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_TIES:
            begin
                if (head_tied)
                begin
                    ties_next = ties_reg + CW'(1);
                end
                if (pass_end)
                begin
                    state_next = S_DRAW;
                end
            end
            S_DRAW:
            begin
                if (ties_reg > CW'(1))
                begin
                    lfsr_next   = lfsr_step;
                    pick_next   = draw_prod[wvc_pkg::LFSR_W+CW-1:wvc_pkg::LFSR_W];
                    picked_next = 1'b0;
                    k_next      = '0;
                    state_next  = S_PICK;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_PICK:
            begin
                if (head_tied && !picked_reg)
                begin
                    if (pick_reg == '0)
                    begin
                        best_label_next = head.label;
                        picked_next     = 1'b1;
                    end
                    else
                    begin
                        pick_next = pick_reg - CW'(1);
                    end
                end
                if (pass_end)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                rv_next    = (best_label_reg != null_reg);
                count_next = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            k_reg      <= '0;
            ties_reg   <= '0;
            pick_reg   <= '0;
            picked_reg <= 1'b0;
            lfsr_reg   <= wvc_pkg::LFSR_SEED;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            k_reg      <= k_next;
            ties_reg   <= ties_next;
            pick_reg   <= pick_next;
            picked_reg <= picked_next;
            lfsr_reg   <= lfsr_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg       <= best_next;
        best_label_reg <= best_label_next;
        if (state_reg == S_MUL)
        begin
            p2_reg <= mul_p[MUL_W-1:wvc_pkg::FRAC_SHIFT];
        end
        if (state_reg == S_DIV1)
        begin
            p3_reg <= mul_p[MUL_W-1:wvc_pkg::FRAC_SHIFT];
            if (div_done)
            begin
                q1_reg <= div_quotient;
            end
        end
        if (state_reg == S_DIV2)
        begin
            p4_reg <= mul_p[wvc_pkg::CONF_W+wvc_pkg::WEIGHT_W-1:wvc_pkg::FRAC_SHIFT];
            if (div_done)
            begin
                q2_reg <= div_quotient;
            end
        end
        if (state_reg == S_OUT)
        begin
            wl_reg     <= best_label_reg;
            ws_out_reg <= best_reg;
        end
    end

    assign result_valid = rv_reg;
    assign winner_label = wl_reg;
    assign winner_score = ws_out_reg;

    // A result only follows the output state.
    a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_OUT))
        else $error("result strobe without output state");

    // The table never holds more entries than there are cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SYSTEMS))
        else $error("entry count beyond table size");

    // The best score belongs to at least one candidate.
    a_ties_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW) |-> (ties_reg != '0))
        else $error("no candidate matches the best score");

    // A draw always lands on one of the tied candidates.
    a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PICK) && pass_end) |=> picked_reg)
        else $error("tie draw found no candidate");

endmodule

// ===== rtl/wvc_cell.sv =====
// One candidate cell of the ring: holds a label with its votes, confidence sum, maximum and score.
module wvc_cell (
    input  logic                        clk,
    input  wvc_pkg::cell_ctl_t          ctl,
    input  logic [wvc_pkg::LABEL_W-1:0] label,
    input  logic [wvc_pkg::CONF_W-1:0]  conf,
    input  wvc_pkg::entry_t             shift_in,
    output wvc_pkg::entry_t             entry
);

    wvc_pkg::entry_t            entry_reg;
    wvc_pkg::entry_t            entry_next;
    logic [wvc_pkg::SUM_W:0]    sum_add;

    assign sum_add = {1'b0, entry_reg.sum} + (wvc_pkg::SUM_W + 1)'(conf);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift)
        begin
            entry_next = shift_in;
        end
        else if (ctl.load_new)
        begin
            entry_next.label = label;
            entry_next.votes = wvc_pkg::VOTES_W'(1);
            entry_next.sum   = wvc_pkg::SUM_W'(conf);
            entry_next.max   = conf;
        end
        else if (ctl.merge)
        begin
            if (entry_reg.votes != wvc_pkg::VOTES_MAX)
            begin
                entry_next.votes = entry_reg.votes + wvc_pkg::VOTES_W'(1);
            end
            entry_next.sum = (sum_add > (wvc_pkg::SUM_W + 1)'(wvc_pkg::SUM_MAX))
                             ? wvc_pkg::SUM_MAX : sum_add[wvc_pkg::SUM_W-1:0];
            if (conf > entry_reg.max)
            begin
                entry_next.max = conf;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/wvc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the score terms.
module wvc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wvc_pkg::DIV_W-1:0]  dividend,
    input  logic [wvc_pkg::NSYS_W-1:0] divisor,
    output logic [wvc_pkg::DIV_W-1:0]  quotient,
    output logic                       done
);

    localparam int CNT_W = $clog2(wvc_pkg::DIV_W + 1);

    logic [wvc_pkg::NSYS_W-1:0] rem_reg;
    logic [wvc_pkg::NSYS_W-1:0] dvs_reg;
    logic [wvc_pkg::DIV_W-1:0]  quo_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       done_reg;
    logic [wvc_pkg::NSYS_W:0]   trial;
    logic                       fits;

    assign trial = {rem_reg, quo_reg[wvc_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(wvc_pkg::DIV_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? wvc_pkg::NSYS_W'(trial - {1'b0, dvs_reg})
                            : trial[wvc_pkg::NSYS_W-1:0];
            quo_reg <= {quo_reg[wvc_pkg::DIV_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
